FILE: rtl/core/gmwb_pkg.sv
// ============================================================================
// gmwb_pkg: shared definitions for the grid wall-break search block
// Register map, direction codes and the deque command bundle used by the
// sequencer and by the deque storage.
// ============================================================================
package gmwb_pkg;

    // Default largest grid side, in cells.
    localparam int unsigned MAX_SIDE_DEF = 128;

    // Configuration port.
    localparam int unsigned CFG_W       = 8;
    localparam int unsigned APB_DW      = 32;
    localparam int unsigned APB_AW      = 3;
    localparam int unsigned REG_SEL_BIT = 2;

    // Register select codes (value of the word-select address bit).
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Result width.
    localparam int unsigned OUT_W = 14;

    // Neighbor directions, visited in this order.
    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_UP    = 2'd3;

    // One command to the deque per cycle; at most one bit is set.
    typedef struct packed {
        logic clear;
        logic add_head;
        logic add_tail;
        logic pop;
    } t_dq_op;

endpackage

FILE: rtl/core/gmwb_deque.sv
// ============================================================================
// gmwb_deque: double-ended queue of search entries
// A ring in a single-port-write memory with head, tail and fill count; pops
// return the front entry on the cycle after the pop.
// ============================================================================
module gmwb_deque #(
    parameter int unsigned PTR_W   = 14,
    parameter int unsigned ENTRY_W = 22
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gmwb_pkg::t_dq_op     i_op,
    input  logic [ENTRY_W-1:0]   i_wdata,
    output logic [ENTRY_W-1:0]   o_rdata,
    output logic                 o_empty
);

    localparam int unsigned RING = 2 ** PTR_W;

    logic [ENTRY_W-1:0] r_mem [RING];
    logic [PTR_W-1:0]   r_head;
    logic [PTR_W-1:0]   r_tail;
    logic [PTR_W:0]     r_count;
    logic [ENTRY_W-1:0] r_rdata;

    logic [PTR_W-1:0]   w_head_dec;
    logic [PTR_W-1:0]   w_waddr;
    logic               w_we;

    assign w_head_dec = r_head - 1'b1;
    assign w_waddr    = i_op.add_head ? w_head_dec : r_tail;
    assign w_we       = i_op.add_head | i_op.add_tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_op.clear) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_op.add_head) begin
            r_head  <= w_head_dec;
            r_count <= r_count + 1'b1;
        end else if (i_op.add_tail) begin
            r_tail  <= r_tail + 1'b1;
            r_count <= r_count + 1'b1;
        end else if (i_op.pop) begin
            r_head  <= r_head + 1'b1;
            r_count <= r_count - 1'b1;
        end
    end

    // Ring storage: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= i_wdata;
        end
        if (i_op.pop) begin
            r_rdata <= r_mem[r_head];
        end
    end

    assign o_rdata = r_rdata;
    assign o_empty = (r_count == '0);

endmodule

FILE: rtl/core/grid_min_wall_breaks_01bfs_top.sv
// ============================================================================
// grid_min_wall_breaks_01bfs_top: least walls broken to cross a grid
// Loads a wall map one cell per request, then runs a 0-1 breadth-first
// search from the top-left to the bottom-right cell and reports the result.
// ============================================================================
//
//  Channel   Direction  Signals                              Handshake
//  --------  ---------  -----------------------------------  ---------------------------
//  cell in   in         start, busy, i_is_wall               taken when start && !busy
//  result    out        o_done, o_walls_broken               one-cycle strobe, no stall
//  config    in/out     psel, penable, pwrite, paddr,        APB write/read, pready = 1
//                       pwdata, prdata, pready
//
//  Flow: busy stays low during the load, so each cell request is taken
//  when presented. The request that completes the grid starts the search,
//  and busy stays high through the cycle of the result strobe. The search
//  seeds in the start and seed states; a popped cell passes the pop, entry
//  and index states and, unless it is the target, a neighbor step per
//  direction and a check step per in-grid neighbor; the done state gives
//  the result. The single neighbor adder and one read port per map set the pace.
//  Reset: synchronous, active low; it clears the sequencer, the deque
//  pointers, the load position and sets both dimensions to one. The maps
//  need no clearing pass: each visited bit is cleared as its cell loads.
//  The result receiver cannot stall, so a search never waits on it.
//
module grid_min_wall_breaks_01bfs_top #(
    parameter int unsigned MAX_SIDE = gmwb_pkg::MAX_SIDE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gmwb_pkg::APB_AW-1:0]  paddr,
    input  logic [gmwb_pkg::APB_DW-1:0]  pwdata,
    output logic [gmwb_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    // Cell requests.
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_is_wall,
    // Result.
    output logic                         o_done,
    output logic [gmwb_pkg::OUT_W-1:0]   o_walls_broken
);

    import gmwb_pkg::*;

    // Sizes that follow from the largest grid side.
    localparam int unsigned DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int unsigned CW    = $clog2(DEPTH);        // cell index
    localparam int unsigned RW    = $clog2(MAX_SIDE);     // row or column
    localparam int unsigned SW    = $clog2(MAX_SIDE + 1); // side length
    localparam int unsigned WW    = $clog2(2 * MAX_SIDE); // wall count
    localparam int unsigned EW    = 2 * RW + WW;          // deque entry

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_SEED  = 4'd2;
    localparam logic [3:0] S_POP   = 4'd3;
    localparam logic [3:0] S_ENT   = 4'd4;
    localparam logic [3:0] S_IDX   = 4'd5;
    localparam logic [3:0] S_NB    = 4'd6;
    localparam logic [3:0] S_CHK   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic             w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W'(1);
            r_height <= CFG_W'(1);
        end else if (w_cfg_wr) begin
            unique case (paddr[REG_SEL_BIT])
                REG_WIDTH:  r_width  <= pwdata[CFG_W-1:0];
                REG_HEIGHT: r_height <= pwdata[CFG_W-1:0];
                default:    r_width  <= r_width;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[REG_SEL_BIT])
            REG_WIDTH:  prdata[CFG_W-1:0] = r_width;
            REG_HEIGHT: prdata[CFG_W-1:0] = r_height;
            default:    prdata = '0;
        endcase
    end

    // Effective dimensions: zero counts as one, anything above the largest
    // side is held at the largest side.
    logic [SW-1:0] w_wid;
    logic [SW-1:0] w_hgt;

    always_comb begin
        if (r_width == '0) begin
            w_wid = SW'(1);
        end else if (32'(r_width) > MAX_SIDE) begin
            w_wid = SW'(MAX_SIDE);
        end else begin
            w_wid = SW'(r_width);
        end
        if (r_height == '0) begin
            w_hgt = SW'(1);
        end else if (32'(r_height) > MAX_SIDE) begin
            w_hgt = SW'(MAX_SIDE);
        end else begin
            w_hgt = SW'(r_height);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer registers.
    // ------------------------------------------------------------------
    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_lp, n_lp;          // load position
    logic [1:0]    r_dir, n_dir;        // neighbor being examined
    logic [RW-1:0] r_row, n_row;        // popped cell
    logic [RW-1:0] r_col, n_col;
    logic [WW-1:0] r_walls, n_walls;    // walls up to and including it
    logic [CW-1:0] r_cell, n_cell;      // its linear index
    logic [CW-1:0] r_nidx, n_nidx;      // neighbor under test
    logic [RW-1:0] r_nrow, n_nrow;
    logic [RW-1:0] r_ncol, n_ncol;

    // Map storage and read data.
    logic          r_wall_map [DEPTH];
    logic          r_vis_map  [DEPTH];
    logic          r_wall_q;
    logic          r_vis_q;

    logic          w_accept;
    logic [CW-1:0] w_rd_addr;
    logic          w_vis_we;
    logic [CW-1:0] w_vis_addr;
    logic          w_vis_din;

    // Deque connection.
    t_dq_op        w_dq_op;
    logic [EW-1:0] w_dq_wdata;
    logic [EW-1:0] w_dq_rdata;
    logic          w_dq_empty;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start & ~busy;

    // Load completion: the cell count is recomputed every cycle so a size
    // written just before the next request takes effect at once.
    logic [2*SW-1:0] w_prod_total;
    logic [CW:0]     w_total;
    logic [CW:0]     w_lp_inc;

    assign w_prod_total = w_wid * w_hgt;
    assign w_total      = (CW + 1)'(w_prod_total);
    assign w_lp_inc     = {1'b0, r_lp} + 1'b1;

    // Linear index of the popped cell: one of the two multipliers in the block.
    logic [RW+SW-1:0] w_prod_rc;
    logic [CW-1:0]    w_cell_calc;

    assign w_prod_rc   = r_row * w_wid;
    assign w_cell_calc = CW'(w_prod_rc) + CW'(r_col);

    // The target is the bottom-right cell.
    logic w_is_target;
    assign w_is_target = (SW'(r_row) == (w_hgt - SW'(1)))
                      && (SW'(r_col) == (w_wid - SW'(1)));

    // Shared neighbor unit: one adder steps the index by one column or one
    // row, and a small decoder does the bounds test and the new coordinates.
    logic [CW-1:0] w_nb_op;
    logic          w_nb_sub;
    logic [CW-1:0] w_nb_idx;
    logic          w_inb;
    logic [RW-1:0] w_nb_row;
    logic [RW-1:0] w_nb_col;

    assign w_nb_op  = ((r_dir == DIR_RIGHT) || (r_dir == DIR_LEFT)) ? CW'(1) : CW'(w_wid);
    assign w_nb_sub = (r_dir == DIR_LEFT) || (r_dir == DIR_UP);
    assign w_nb_idx = w_nb_sub ? (r_cell - w_nb_op) : (r_cell + w_nb_op);

    always_comb begin
        w_nb_row = r_row;
        w_nb_col = r_col;
        unique case (r_dir)
            DIR_RIGHT: begin
                w_inb    = (SW'(r_col) + SW'(1)) < w_wid;
                w_nb_col = r_col + 1'b1;
            end
            DIR_LEFT: begin
                w_inb    = (r_col != '0);
                w_nb_col = r_col - 1'b1;
            end
            DIR_DOWN: begin
                w_inb    = (SW'(r_row) + SW'(1)) < w_hgt;
                w_nb_row = r_row + 1'b1;
            end
            DIR_UP: begin
                w_inb    = (r_row != '0);
                w_nb_row = r_row - 1'b1;
            end
            default: begin
                w_inb = 1'b0;
            end
        endcase
    end

    // Walls carried by a pushed neighbor include its own cost, so a pop
    // needs no extra map read.
    logic [WW-1:0] w_push_walls;
    assign w_push_walls = r_walls + WW'(r_wall_q);

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_lp       = r_lp;
        n_dir      = r_dir;
        n_row      = r_row;
        n_col      = r_col;
        n_walls    = r_walls;
        n_cell     = r_cell;
        n_nidx     = r_nidx;
        n_nrow     = r_nrow;
        n_ncol     = r_ncol;
        w_dq_op    = '0;
        w_dq_wdata = {r_nrow, r_ncol, w_push_walls};
        w_vis_we   = 1'b0;
        w_vis_addr = r_nidx;
        w_vis_din  = 1'b1;
        w_rd_addr  = w_nb_idx;

        unique case (r_state)
            S_IDLE: begin
                // Each loaded cell also clears its visited bit, which
                // prepares the map for the coming search.
                if (w_accept) begin
                    w_vis_we   = 1'b1;
                    w_vis_addr = r_lp;
                    w_vis_din  = 1'b0;
                    if (w_lp_inc >= w_total) begin
                        n_lp    = '0;
                        n_state = S_START;
                    end else begin
                        n_lp = w_lp_inc[CW-1:0];
                    end
                end
            end
            S_START: begin
                w_rd_addr     = '0;
                w_dq_op.clear = 1'b1;
                n_state       = S_SEED;
            end
            S_SEED: begin
                w_dq_op.add_head = 1'b1;
                w_dq_wdata       = {RW'(0), RW'(0), WW'(r_wall_q)};
                w_vis_we         = 1'b1;
                w_vis_addr       = '0;
                n_state          = S_POP;
            end
            S_POP: begin
                if (w_dq_empty) begin
                    n_walls = '0;
                    n_state = S_DONE;
                end else begin
                    w_dq_op.pop = 1'b1;
                    n_state     = S_ENT;
                end
            end
            S_ENT: begin
                {n_row, n_col, n_walls} = w_dq_rdata;
                n_state                 = S_IDX;
            end
            S_IDX: begin
                if (w_is_target) begin
                    n_state = S_DONE;
                end else begin
                    n_cell  = w_cell_calc;
                    n_dir   = DIR_RIGHT;
                    n_state = S_NB;
                end
            end
            S_NB: begin
                if (w_inb) begin
                    n_nidx  = w_nb_idx;
                    n_nrow  = w_nb_row;
                    n_ncol  = w_nb_col;
                    n_state = S_CHK;
                end else if (r_dir == DIR_UP) begin
                    n_state = S_POP;
                end else begin
                    n_dir = r_dir + 1'b1;
                end
            end
            S_CHK: begin
                // Open neighbors go to the front, walls to the back.
                if (!r_vis_q) begin
                    w_vis_we = 1'b1;
                    if (r_wall_q) begin
                        w_dq_op.add_tail = 1'b1;
                    end else begin
                        w_dq_op.add_head = 1'b1;
                    end
                end
                if (r_dir == DIR_UP) begin
                    n_state = S_POP;
                end else begin
                    n_dir   = r_dir + 1'b1;
                    n_state = S_NB;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lp    <= '0;
            r_dir   <= DIR_RIGHT;
        end else begin
            r_state <= n_state;
            r_lp    <= n_lp;
            r_dir   <= n_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row   <= n_row;
        r_col   <= n_col;
        r_walls <= n_walls;
        r_cell  <= n_cell;
        r_nidx  <= n_nidx;
        r_nrow  <= n_nrow;
        r_ncol  <= n_ncol;
    end

    // Wall map: written while loading, read during the search.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_wall_map[r_lp] <= i_is_wall;
        end
        r_wall_q <= r_wall_map[w_rd_addr];
    end

    // Visited map: cleared while loading, set as cells enter the deque.
    always_ff @(posedge i_clk) begin
        if (w_vis_we) begin
            r_vis_map[w_vis_addr] <= w_vis_din;
        end
        r_vis_q <= r_vis_map[w_rd_addr];
    end

    gmwb_deque #(
        .PTR_W   (CW),
        .ENTRY_W (EW)
    ) u_deque (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_dq_op),
        .i_wdata (w_dq_wdata),
        .o_rdata (w_dq_rdata),
        .o_empty (w_dq_empty)
    );

    // The result is shown for the single cycle spent in the done state.
    assign o_done         = (r_state == S_DONE);
    assign o_walls_broken = OUT_W'(r_walls);

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A search only begins from an accepted cell request.
    a_busy_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a cell request");

    // The seed entry must land in the deque before the first pop.
    a_seed_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEED) |=> !w_dq_empty)
        else $error("deque empty right after seeding");

    // One result per search, then the block is ready again.
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!o_done && !busy))
        else $error("result strobe not followed by idle");

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Regression for grid_min_wall_breaks_01bfs_top
// Loads grids of wall cells through the request port and programs the grid
// size over APB. A software 0-1 search predicts the least walls broken for
// every completed grid, and each result strobe is checked against it.
// ----------------------------------------------------------------------------
module testbench;
    import gmwb_pkg::*;

    localparam int unsigned SIDE         = MAX_SIDE_DEF;
    localparam int unsigned CELLS        = SIDE * SIDE;
    // A full-size search pops up to 16384 cells, so a quiet stretch this
    // long can only be a hang.
    localparam int unsigned QUIET_LIMIT  = 1000000;
    localparam int unsigned RANDOM_CELLS = 1000;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                start;
    logic                busy;
    logic                i_is_wall;
    logic                o_done;
    logic [OUT_W-1:0]    o_walls_broken;

    // Predictor state: programmed size, load position and grid contents.
    logic [CFG_W-1:0]    dim_width;
    logic [CFG_W-1:0]    dim_height;
    int unsigned         cells_loaded;
    bit                  wall_mem [CELLS];
    bit                  seen_mem [CELLS];
    int unsigned         ring_node [CELLS];
    int unsigned         ring_walls [CELLS];

    logic [OUT_W-1:0]    expected_breaks [$];
    logic [OUT_W-1:0]    want_breaks;
    int                  n_errors = 0;
    int unsigned         quiet_cycles = 0;
    int unsigned         cells_sent = 0;
    bit                  quick_feed = 1'b0;

    grid_min_wall_breaks_01bfs_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .i_is_wall      (i_is_wall),
        .o_done         (o_done),
        .o_walls_broken (o_walls_broken)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned clamp_side(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > SIDE) return SIDE;
        return 32'(v);
    endfunction

    function automatic int row_offset(input logic [1:0] dir);
        case (dir)
            DIR_DOWN: return 1;
            DIR_UP:   return -1;
            default:  return 0;
        endcase
    endfunction

    function automatic int col_offset(input logic [1:0] dir);
        case (dir)
            DIR_RIGHT: return 1;
            DIR_LEFT:  return -1;
            default:   return 0;
        endcase
    endfunction

    // 0-1 search over the loaded grid. Cells are marked seen when queued,
    // so a cell keeps the cost of the first path that reached it.
    function automatic logic [OUT_W-1:0] least_breaks();
        int unsigned w, h, target, head, tail, count, node, walls, n;
        int nr, nc;
        logic [1:0] dir;
        w = clamp_side(dim_width);
        h = clamp_side(dim_height);
        target = (h - 1) * w + (w - 1);
        foreach (seen_mem[i]) seen_mem[i] = 1'b0;
        tail = 0;
        head = CELLS - 1;
        ring_node[head] = 0;
        ring_walls[head] = 0;
        count = 1;
        seen_mem[0] = 1'b1;
        while (count > 0) begin
            node = ring_node[head];
            walls = ring_walls[head];
            head = (head + 1) % CELLS;
            count--;
            if (wall_mem[node % CELLS]) walls++;
            if (node == target) return walls[OUT_W-1:0];
            for (int k = 0; k < 4; k++) begin
                dir = 2'(k);
                nr = int'(node / w) + row_offset(dir);
                nc = int'(node % w) + col_offset(dir);
                if (nr < 0 || nc < 0 || nr >= int'(h) || nc >= int'(w)) continue;
                n = (nr * w + nc) % CELLS;
                if (seen_mem[n]) continue;
                seen_mem[n] = 1'b1;
                if (count < CELLS) begin
                    // Walls go to the back, open cells to the front.
                    if (wall_mem[n]) begin
                        ring_node[tail] = n;
                        ring_walls[tail] = walls;
                        tail = (tail + 1) % CELLS;
                    end else begin
                        head = (head + CELLS - 1) % CELLS;
                        ring_node[head] = n;
                        ring_walls[head] = walls;
                    end
                    count++;
                end
            end
        end
        return '0;
    endfunction

    // The size in force when a cell arrives decides whether it ends the load.
    function automatic void absorb_cell(input logic wall);
        int unsigned total;
        total = clamp_side(dim_width) * clamp_side(dim_height);
        wall_mem[cells_loaded % CELLS] = wall;
        cells_loaded++;
        if (cells_loaded >= total) begin
            cells_loaded = 0;
            expected_breaks = {expected_breaks, least_breaks()};
        end
    endfunction

    // Start stays high across back-to-back requests; it only drops for a gap.
    task automatic send_cell(input logic wall);
        int unsigned gap;
        gap = quick_feed ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_is_wall <= wall;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        cells_sent++;
        absorb_cell(wall);
    endtask

    // Drains outstanding results and lets the block go quiet.
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_breaks.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write followed by a read back of the same register.
    task automatic write_dim(input logic sel, input logic [CFG_W-1:0] value);
        logic [APB_AW-1:0] addr;
        logic [APB_DW-1:0] word;
        addr = '0;
        addr[REG_SEL_BIT] = sel;
        word = $urandom();
        word[CFG_W-1:0] = value;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (sel == REG_WIDTH) dim_width = value;
        else dim_height = value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[CFG_W-1:0] !== value) begin
            $display("%0t: register %0d read back, expected %0d, actual %0d",
                     $time, sel, value, prdata[CFG_W-1:0]);
            n_errors++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        settle();
        write_dim(REG_WIDTH, w);
        write_dim(REG_HEIGHT, h);
    endtask

    // Sends a fixed grid, first cell in bit 0.
    task automatic load_pattern(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                input logic [63:0] pattern);
        set_size(w, h);
        for (int i = 0; i < clamp_side(w) * clamp_side(h); i++) send_cell(pattern[i]);
    endtask

    // Sends random cells until the current load completes.
    task automatic load_random(input int unsigned wall_pct);
        do begin
            send_cell($urandom_range(0, 99) < wall_pct);
        end while (cells_loaded != 0);
    endtask

    function automatic logic [CFG_W-1:0] pick_side();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 15) return CFG_W'($urandom_range(1, 6));
        if (r < 18) return CFG_W'($urandom_range(7, 16));
        if (r == 18) return '0;
        return CFG_W'($urandom_range(1, 255));
    endfunction

    // Both sizes default to one after reset, so a single cell is a grid.
    task automatic test_one_cell_grids();
        quick_feed = 1'b0;
        send_cell(1'b0);
        send_cell(1'b1);
        set_size('0, '0);
        send_cell(1'b1);
        send_cell(1'b0);
    endtask

    task automatic test_small_grids();
        load_pattern(8'd3, 8'd1, 64'b101);
        load_pattern(8'd3, 8'd3, 64'b010_111_010);
    endtask

    // Resizing part way through a load: a smaller grid ends the load on the
    // next cell, a larger one extends it.
    task automatic test_resize_mid_load();
        set_size(8'd4, 8'd4);
        for (int i = 0; i < 6; i++) send_cell(i[0]);
        set_size(8'd2, 8'd2);
        send_cell(1'b1);
        set_size(8'd2, 8'd1);
        send_cell(1'b1);
        set_size(8'd2, 8'd2);
        load_random(50);
    endtask

    // Largest sides, including register values beyond the largest side.
    task automatic test_large_grids();
        set_size(8'd128, 8'd1);
        load_random(40);
        set_size(8'd1, 8'd255);
        load_random(40);
        set_size(8'd200, 8'd2);
        load_random(60);
        set_size(8'd129, 8'd3);
        quick_feed = 1'b1;
        load_random(35);
        quick_feed = 1'b0;
    endtask

    // Mostly complete grids with random content; some grids follow straight
    // on once the previous search ends, some are resized part way.
    task automatic test_random_grids();
        int unsigned base, total, part;
        logic [CFG_W-1:0] w, h;
        base = cells_sent;
        while (cells_sent - base < RANDOM_CELLS) begin
            if (cells_sent == base || $urandom_range(0, 2) != 0) begin
                w = pick_side();
                h = pick_side();
                if (clamp_side(w) * clamp_side(h) > 1024) h = CFG_W'($urandom_range(0, 2));
                set_size(w, h);
            end
            quick_feed = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) begin
                total = clamp_side(dim_width) * clamp_side(dim_height);
                part = $urandom_range(0, total - 1);
                for (int i = 0; i < part; i++) send_cell(1'($urandom_range(0, 1)));
                set_size(CFG_W'($urandom_range(0, 8)), CFG_W'($urandom_range(0, 8)));
            end
            load_random(25 * $urandom_range(0, 4));
        end
        quick_feed = 1'b0;
    endtask

    // Results are checked in the order the grids completed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_breaks.size() == 0) begin
                $display("%0t: walls_broken expected none, actual %0d",
                         $time, o_walls_broken);
                n_errors++;
            end else begin
                want_breaks = expected_breaks[0];
                expected_breaks.delete(0);
                if (o_walls_broken !== want_breaks) begin
                    $display("%0t: walls_broken expected %0d, actual %0d",
                             $time, want_breaks, o_walls_broken);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (psel && penable)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("grid_min_wall_breaks_01bfs_top regression: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        i_is_wall = 1'b0;
        dim_width = 8'd1;
        dim_height = 8'd1;
        cells_loaded = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_one_cell_grids();
        test_small_grids();
        test_resize_mid_load();
        test_large_grids();
        test_random_grids();

        settle();
        repeat (20) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("grid_min_wall_breaks_01bfs_top regression: pass");
        end else begin
            $display("grid_min_wall_breaks_01bfs_top regression: fail");
        end
        $finish;
    end

endmodule
